FILE: design/srv_pkg.sv
`timescale 1ns / 1ps

package srv_pkg;

  localparam int MAX_SECTIONS = 32;
  localparam int ADDR_W = $clog2(MAX_SECTIONS);
  localparam int CNT_W = $clog2(MAX_SECTIONS + 1);

  localparam logic [1:0] ACT_LOAD     = 2'd0;
  localparam logic [1:0] ACT_RELOC    = 2'd1;
  localparam logic [1:0] ACT_VALIDATE = 2'd2;

  localparam logic [1:0] KIND_SECTION = 2'd0;
  localparam logic [1:0] KIND_RELOC   = 2'd1;
  localparam logic [1:0] KIND_FINAL   = 2'd2;

  localparam logic CFG_IMAGE_PRESENT = 1'b0;
  localparam logic CFG_IMAGE_SIZE    = 1'b1;

  typedef struct packed {
    logic        present;
    logic        no_bits;
    logic [63:0] offset;
    logic [63:0] size;
  } slot_t;

  typedef struct packed {
    logic load;
    logic reloc_start;
    logic reloc_emit;
    logic v_start;
    logic rd_i;
    logic scan;
    logic sec_emit;
    logic fin_emit;
  } srv_cmd_t;

  typedef struct packed {
    logic out_free;
    logic scan_done;
    logic last_sec;
    logic empty;
  } srv_stat_t;

endpackage

FILE: design/section_range_validator.sv
`timescale 1ns / 1ps
// Channel  Direction  Handshake            Payload
// in_      request    in_valid / in_stall  action, entry_present, no_bits, byte_offset,
//                                          byte_size, has_target, target_index
// out_     result     out_valid/out_stall  report_kind, item_index, missing_entry,
//                                          out_of_bounds, overlap_mask,
//                                          reloc_out_of_range, format_error, last
// cfg_     write      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// A section load is stored when it is accepted; a relocation check reads its target
// entry and then waits for the output register to be free. A validate request reads
// each stored section i in turn, scans sections i+1 onwards for overlap and emits the
// section result, then emits the final status. Overlaps are found by the single
// pair-compare unit fed from the second read port of the section memory.
// Reset is synchronous and active low and clears the counters, error flag, image
// configuration, output valid and control state. The request channel stalls while a
// request is in progress; out_stall only holds the output register and delays the next result.

module section_range_validator (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_action,
  input  logic        in_entry_present,
  input  logic        in_no_bits,
  input  logic [63:0] in_byte_offset,
  input  logic [63:0] in_byte_size,
  input  logic        in_has_target,
  input  logic [4:0]  in_target_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_report_kind,
  output logic [15:0] out_item_index,
  output logic        out_missing_entry,
  output logic        out_out_of_bounds,
  output logic [31:0] out_overlap_mask,
  output logic        out_reloc_out_of_range,
  output logic        out_format_error,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data
);
  import srv_pkg::*;

  srv_cmd_t  cmd;
  srv_stat_t stat;

  assign cfg_ready = 1'b1;

  srv_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_action),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  srv_datapath u_dp (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cmd                    (cmd),
    .stat                   (stat),
    .in_entry_present       (in_entry_present),
    .in_no_bits             (in_no_bits),
    .in_byte_offset         (in_byte_offset),
    .in_byte_size           (in_byte_size),
    .in_has_target          (in_has_target),
    .in_target_index        (in_target_index),
    .cfg_we                 (cfg_valid && cfg_ready),
    .cfg_index              (cfg_index),
    .cfg_data               (cfg_data),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .out_report_kind        (out_report_kind),
    .out_item_index         (out_item_index),
    .out_missing_entry      (out_missing_entry),
    .out_out_of_bounds      (out_out_of_bounds),
    .out_overlap_mask       (out_overlap_mask),
    .out_reloc_out_of_range (out_reloc_out_of_range),
    .out_format_error       (out_format_error),
    .out_last               (out_last)
  );

endmodule

FILE: design/srv_ctrl.sv
`timescale 1ns / 1ps

module srv_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [1:0]       in_action,
  output logic             in_stall,
  input  srv_pkg::srv_stat_t stat,
  output srv_pkg::srv_cmd_t  cmd
);
  import srv_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RELOC = 3'd1;
  localparam logic [2:0] ST_RDI   = 3'd2;
  localparam logic [2:0] ST_SCAN  = 3'd3;
  localparam logic [2:0] ST_EMIT  = 3'd4;
  localparam logic [2:0] ST_FINAL = 3'd5;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          case (in_action)
            ACT_LOAD: begin
              cmd.load = 1'b1;
            end
            ACT_RELOC: begin
              cmd.reloc_start = 1'b1;
              state_nxt       = ST_RELOC;
            end
            ACT_VALIDATE: begin
              cmd.v_start = 1'b1;
              state_nxt   = stat.empty ? ST_FINAL : ST_RDI;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RELOC: begin
        if (stat.out_free) begin
          cmd.reloc_emit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      ST_RDI: begin
        cmd.rd_i  = 1'b1;
        state_nxt = ST_SCAN;
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_done) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.sec_emit = 1'b1;
          state_nxt    = stat.last_sec ? ST_FINAL : ST_RDI;
        end
      end
      ST_FINAL: begin
        if (stat.out_free) begin
          cmd.fin_emit = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: design/srv_datapath.sv
`timescale 1ns / 1ps

module srv_datapath (
  input  logic               clk,
  input  logic               rst_n,
  input  srv_pkg::srv_cmd_t  cmd,
  output srv_pkg::srv_stat_t stat,
  input  logic               in_entry_present,
  input  logic               in_no_bits,
  input  logic [63:0]        in_byte_offset,
  input  logic [63:0]        in_byte_size,
  input  logic               in_has_target,
  input  logic [4:0]         in_target_index,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [63:0]        cfg_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [1:0]         out_report_kind,
  output logic [15:0]        out_item_index,
  output logic               out_missing_entry,
  output logic               out_out_of_bounds,
  output logic [31:0]        out_overlap_mask,
  output logic               out_reloc_out_of_range,
  output logic               out_format_error,
  output logic               out_last
);
  import srv_pkg::*;

  slot_t slot_mem [MAX_SECTIONS];

  slot_t             slot_a_r;
  slot_t             slot_b_r;
  logic [CNT_W-1:0]  loaded_r;
  logic [15:0]       relocs_r;
  logic              err_r;
  logic              img_present_r;
  logic [63:0]       img_size_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  j_r;
  logic [CNT_W-1:0]  jd_r;
  logic              pend_r;
  logic [31:0]       mask_r;
  logic [63:0]       off_r;
  logic              has_t_r;
  logic [4:0]        tgt_r;

  logic              out_valid_r;
  logic [1:0]        kind_r;
  logic [15:0]       idx_r;
  logic              miss_r;
  logic              oob_r;
  logic [31:0]       omask_r;
  logic              rr_r;
  logic              ferr_r;
  logic              last_r;

  logic [ADDR_W-1:0] addr_a;
  logic              full;
  logic              scan_issue;
  logic              occ_a;
  logic              occ_b;
  logic [64:0]       end_a;
  logic [64:0]       end_b;
  logic              ovl;
  logic              sec_oob;
  logic              sec_miss;
  logic              rel_miss;
  logic              rel_rr;

  assign addr_a     = cmd.reloc_start ? ADDR_W'(in_target_index) : i_r[ADDR_W-1:0];
  assign full       = (loaded_r == CNT_W'(MAX_SECTIONS));
  assign scan_issue = cmd.scan && (j_r < loaded_r);

  assign occ_a = slot_a_r.present && !slot_a_r.no_bits && (slot_a_r.size != 64'd0);
  assign occ_b = slot_b_r.present && !slot_b_r.no_bits && (slot_b_r.size != 64'd0);
  assign end_a = {1'b0, slot_a_r.offset} + {1'b0, slot_a_r.size};
  assign end_b = {1'b0, slot_b_r.offset} + {1'b0, slot_b_r.size};
  assign ovl   = pend_r && occ_a && occ_b && ({1'b0, slot_a_r.offset} < end_b) &&
                 ({1'b0, slot_b_r.offset} < end_a);

  assign sec_oob  = occ_a && img_present_r && (end_a > {1'b0, img_size_r});
  assign sec_miss = !slot_a_r.present;
  assign rel_miss = !has_t_r || (32'(tgt_r) >= 32'(loaded_r)) || !slot_a_r.present;
  assign rel_rr   = !rel_miss && !slot_a_r.no_bits && (off_r >= slot_a_r.size);

  assign stat.out_free  = !out_valid_r || !out_stall;
  assign stat.scan_done = !(j_r < loaded_r) && !pend_r;
  assign stat.last_sec  = ((i_r + CNT_W'(1)) >= loaded_r);
  assign stat.empty     = (loaded_r == '0);

  always_ff @(posedge clk) begin
    if (cmd.load && !full) begin
      slot_mem[loaded_r[ADDR_W-1:0]] <= '{present: in_entry_present, no_bits: in_no_bits,
                                          offset: in_byte_offset, size: in_byte_size};
    end
    if (cmd.reloc_start || cmd.rd_i) begin
      slot_a_r <= slot_mem[addr_a];
    end
    if (scan_issue) begin
      slot_b_r <= slot_mem[j_r[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.reloc_start) begin
      off_r   <= in_byte_offset;
      has_t_r <= in_has_target;
      tgt_r   <= in_target_index;
    end
    if (cmd.v_start) begin
      i_r <= '0;
    end
    if (cmd.rd_i) begin
      j_r    <= i_r + CNT_W'(1);
      mask_r <= '0;
    end
    if (cmd.scan) begin
      jd_r <= j_r;
      if (scan_issue) begin
        j_r <= j_r + CNT_W'(1);
      end
    end
    if (ovl) begin
      mask_r <= mask_r | (32'd1 << jd_r);
    end
    if (cmd.reloc_emit) begin
      kind_r  <= KIND_RELOC;
      idx_r   <= relocs_r;
      miss_r  <= rel_miss;
      oob_r   <= 1'b0;
      omask_r <= '0;
      rr_r    <= rel_rr;
      ferr_r  <= 1'b0;
      last_r  <= 1'b1;
    end
    if (cmd.sec_emit) begin
      kind_r  <= KIND_SECTION;
      idx_r   <= 16'(i_r);
      miss_r  <= sec_miss;
      oob_r   <= sec_oob;
      omask_r <= mask_r;
      rr_r    <= 1'b0;
      ferr_r  <= 1'b0;
      last_r  <= 1'b0;
      i_r     <= i_r + CNT_W'(1);
    end
    if (cmd.fin_emit) begin
      kind_r  <= KIND_FINAL;
      idx_r   <= 16'(loaded_r);
      miss_r  <= 1'b0;
      oob_r   <= 1'b0;
      omask_r <= '0;
      rr_r    <= 1'b0;
      ferr_r  <= err_r;
      last_r  <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r      <= '0;
      relocs_r      <= '0;
      err_r         <= 1'b0;
      img_present_r <= 1'b0;
      img_size_r    <= '0;
      pend_r        <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_IMAGE_PRESENT: img_present_r <= cfg_data[0];
          CFG_IMAGE_SIZE:    img_size_r    <= cfg_data;
          default: begin
          end
        endcase
      end
      if (cmd.load) begin
        if (full) begin
          err_r <= 1'b1;
        end else begin
          loaded_r <= loaded_r + CNT_W'(1);
        end
      end
      if (cmd.rd_i) begin
        pend_r <= 1'b0;
      end
      if (cmd.scan) begin
        pend_r <= scan_issue;
      end
      if (ovl) begin
        err_r <= 1'b1;
      end
      if (cmd.reloc_emit) begin
        relocs_r <= relocs_r + 16'd1;
        if (rel_miss || rel_rr) begin
          err_r <= 1'b1;
        end
      end
      if (cmd.sec_emit && (sec_miss || sec_oob)) begin
        err_r <= 1'b1;
      end
      if (cmd.fin_emit) begin
        loaded_r <= '0;
        relocs_r <= '0;
        err_r    <= 1'b0;
      end
      if (cmd.reloc_emit || cmd.sec_emit || cmd.fin_emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_report_kind        = kind_r;
  assign out_item_index         = idx_r;
  assign out_missing_entry      = miss_r;
  assign out_out_of_bounds      = oob_r;
  assign out_overlap_mask       = omask_r;
  assign out_reloc_out_of_range = rr_r;
  assign out_format_error       = ferr_r;
  assign out_last               = last_r;

endmodule

FILE: design/srv_checker.sv
`timescale 1ns / 1ps

module srv_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_stall,
  input logic [1:0]  in_action,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_report_kind,
  input logic [15:0] out_item_index,
  input logic        out_out_of_bounds,
  input logic [31:0] out_overlap_mask,
  input logic        out_reloc_out_of_range,
  input logic        out_format_error,
  input logic        out_last
);
  import srv_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item_index) &&
    $stable(out_report_kind))
    else $error("stalled result changed");

  a_reloc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_action == ACT_RELOC |=> in_stall)
    else $error("relocation request not held busy");

  a_final_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_report_kind == KIND_FINAL || out_report_kind == KIND_RELOC)
    |-> out_last)
    else $error("final or relocation result without last");

  a_section_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == KIND_SECTION |->
    !out_last && !out_reloc_out_of_range && !out_format_error)
    else $error("section result carries foreign fields");

  a_reloc_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_report_kind == KIND_RELOC |->
    out_overlap_mask == 32'd0 && !out_out_of_bounds && !out_format_error)
    else $error("relocation result carries foreign fields");

endmodule

bind section_range_validator srv_checker u_srv_checker (.*);

FILE: sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import srv_pkg::*;

  localparam logic [1:0] ACT_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 20000;
  localparam int SETTLE_CYCLES = 40;
  localparam int HOLD_CYCLES = 400;
  localparam int RANDOM_ITEMS = 200;
  localparam int HOLD_ITEMS = 30;

  typedef struct packed {
    logic [1:0]  action;
    logic        present;
    logic        no_bits;
    logic [63:0] offset;
    logic [63:0] size;
    logic        has_target;
    logic [4:0]  target;
  } req_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [15:0] index;
    logic        missing;
    logic        oob;
    logic [31:0] mask;
    logic        rr;
    logic        ferr;
    logic        last;
  } report_t;

  typedef enum logic [1:0] {ROW_REQ, ROW_CHK, ROW_CFG} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    req_t        req;
    report_t     want;
    logic        img_p;
    logic [63:0] img_s;
  } row_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic [1:0] in_action;
  logic in_entry_present;
  logic in_no_bits;
  logic [63:0] in_byte_offset;
  logic [63:0] in_byte_size;
  logic in_has_target;
  logic [4:0] in_target_index;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [1:0] out_report_kind;
  logic [15:0] out_item_index;
  logic out_missing_entry;
  logic out_out_of_bounds;
  logic [31:0] out_overlap_mask;
  logic out_reloc_out_of_range;
  logic out_format_error;
  logic out_last;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [63:0] cfg_data;

  section_range_validator u_top (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_action(in_action),
    .in_entry_present(in_entry_present),
    .in_no_bits(in_no_bits),
    .in_byte_offset(in_byte_offset),
    .in_byte_size(in_byte_size),
    .in_has_target(in_has_target),
    .in_target_index(in_target_index),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_report_kind(out_report_kind),
    .out_item_index(out_item_index),
    .out_missing_entry(out_missing_entry),
    .out_out_of_bounds(out_out_of_bounds),
    .out_overlap_mask(out_overlap_mask),
    .out_reloc_out_of_range(out_reloc_out_of_range),
    .out_format_error(out_format_error),
    .out_last(out_last),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #2 clk = ~clk;

  slot_t sec_tab [MAX_SECTIONS];
  logic [CNT_W-1:0] sec_count;
  logic [15:0] reloc_seq;
  logic err_flag;
  logic img_present;
  logic [63:0] img_size;

  report_t reports_due [$];
  int mismatches = 0;
  int burst_left = 0;
  logic hold_request = 1'b0;

  function automatic logic occupies(input slot_t s);
    return s.present && !s.no_bits && s.size != 64'd0;
  endfunction

  function automatic logic ranges_meet(input slot_t a, input slot_t b);
    return ({1'b0, a.offset} < {1'b0, b.offset} + {1'b0, b.size}) &&
           ({1'b0, b.offset} < {1'b0, a.offset} + {1'b0, a.size});
  endfunction

  task automatic predict_reports(input req_t r);
    report_t rep;
    logic miss;
    logic any_err;
    slot_t tgt;
    case (r.action)
      ACT_LOAD: begin
        if (sec_count >= CNT_W'(MAX_SECTIONS)) begin
          err_flag = 1'b1;
        end else begin
          sec_tab[sec_count[ADDR_W-1:0]] = '{r.present, r.no_bits, r.offset, r.size};
          sec_count = sec_count + 1'b1;
        end
      end
      ACT_RELOC: begin
        tgt = sec_tab[r.target];
        miss = !r.has_target || {1'b0, r.target} >= sec_count || !tgt.present;
        rep = '0;
        rep.kind = KIND_RELOC;
        rep.index = reloc_seq;
        rep.missing = miss;
        rep.rr = !miss && !tgt.no_bits && r.offset >= tgt.size;
        rep.last = 1'b1;
        if (rep.missing || rep.rr) err_flag = 1'b1;
        reports_due.push_back(rep);
        reloc_seq = reloc_seq + 16'd1;
      end
      ACT_VALIDATE: begin
        any_err = err_flag;
        for (int i = 0; i < int'(sec_count); i++) begin
          rep = '0;
          rep.kind = KIND_SECTION;
          rep.index = 16'(i);
          rep.missing = !sec_tab[i].present;
          if (occupies(sec_tab[i])) begin
            rep.oob = img_present &&
                      ({1'b0, sec_tab[i].offset} + {1'b0, sec_tab[i].size} > {1'b0, img_size});
            for (int j = i + 1; j < int'(sec_count); j++) begin
              if (occupies(sec_tab[j]) && ranges_meet(sec_tab[i], sec_tab[j])) begin
                any_err = 1'b1;
                if (j < 32) rep.mask[j] = 1'b1;
              end
            end
          end
          if (rep.missing || rep.oob) any_err = 1'b1;
          reports_due.push_back(rep);
        end
        rep = '0;
        rep.kind = KIND_FINAL;
        rep.index = 16'(sec_count);
        rep.ferr = any_err;
        rep.last = 1'b1;
        reports_due.push_back(rep);
        sec_count = '0;
        reloc_seq = '0;
        err_flag = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_request(input req_t r, input logic typed, input report_t want);
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
    end
    burst_left--;
    predict_reports(r);
    if (typed) reports_due[reports_due.size() - 1] = want;
    in_valid <= 1'b1;
    in_action <= r.action;
    in_entry_present <= r.present;
    in_no_bits <= r.no_bits;
    in_byte_offset <= r.offset;
    in_byte_size <= r.size;
    in_has_target <= r.has_target;
    in_target_index <= r.target;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    while (reports_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_image(input logic present, input logic [63:0] size);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= CFG_IMAGE_PRESENT;
    cfg_data <= {junk[63:1], present};
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_index <= CFG_IMAGE_SIZE;
    cfg_data <= size;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    img_present = present;
    img_size = size;
  endtask

  function automatic req_t make_req(input logic [1:0] action);
    req_t r;
    r.action = action;
    r.present = 1'($urandom);
    r.no_bits = 1'($urandom);
    r.offset = {$urandom, $urandom};
    r.size = {$urandom, $urandom};
    r.has_target = 1'($urandom);
    r.target = 5'($urandom);
    return r;
  endfunction

  function automatic req_t random_load();
    req_t r;
    int pick;
    r = make_req(ACT_LOAD);
    r.present = ($urandom_range(0, 9) != 0);
    r.no_bits = ($urandom_range(0, 6) == 0);
    pick = $urandom_range(0, 9);
    if (pick < 7) begin
      r.offset = 64'($urandom_range(0, 'h300));
      r.size = ($urandom_range(0, 7) == 0) ? 64'd0 : 64'($urandom_range(1, 'h100));
    end else if (pick < 9) begin
      r.offset = '1 - 64'($urandom_range(0, 'h200));
      r.size = 64'($urandom_range(0, 'h400));
    end
    return r;
  endfunction

  function automatic req_t random_reloc();
    req_t r;
    int pick;
    r = make_req(ACT_RELOC);
    r.has_target = ($urandom_range(0, 9) != 0);
    if (sec_count != 0 && $urandom_range(0, 4) != 0) begin
      r.target = 5'($urandom_range(0, int'(sec_count) - 1));
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
        r.offset = sec_tab[r.target].size - 64'd1 + 64'($urandom_range(0, 2));
      end else if (pick < 9) begin
        r.offset = 64'($urandom_range(0, 'h100));
      end
    end
    return r;
  endfunction

  function automatic row_t load_row(input logic p, input logic nb, input logic [63:0] off,
                                    input logic [63:0] size);
    row_t row;
    row = '{ROW_REQ, make_req(ACT_LOAD), '0, 1'b0, '0};
    row.req.present = p;
    row.req.no_bits = nb;
    row.req.offset = off;
    row.req.size = size;
    return row;
  endfunction

  function automatic row_t reloc_row(input logic has, input logic [4:0] tgt,
                                     input logic [63:0] off, input logic [15:0] seq,
                                     input logic miss, input logic rr);
    row_t row;
    row = '{ROW_CHK, make_req(ACT_RELOC), '0, 1'b0, '0};
    row.req.has_target = has;
    row.req.target = tgt;
    row.req.offset = off;
    row.want.kind = KIND_RELOC;
    row.want.index = seq;
    row.want.missing = miss;
    row.want.rr = rr;
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic row_t validate_row();
    return '{ROW_REQ, make_req(ACT_VALIDATE), '0, 1'b0, '0};
  endfunction

  function automatic row_t final_row(input logic ferr);
    row_t row;
    row = '{ROW_CHK, make_req(ACT_VALIDATE), '0, 1'b0, '0};
    row.want.kind = KIND_FINAL;
    row.want.ferr = ferr;
    row.want.last = 1'b1;
    return row;
  endfunction

  function automatic row_t image_row(input logic p, input logic [63:0] size);
    return '{ROW_CFG, '0, '0, p, size};
  endfunction

  initial begin
    row_t dir_rows [$];
    row_t noise;
    int random_items;
    int n;
    int r;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_LOAD;
    in_entry_present = 1'b0;
    in_no_bits = 1'b0;
    in_byte_offset = '0;
    in_byte_size = '0;
    in_has_target = 1'b0;
    in_target_index = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_IMAGE_PRESENT;
    cfg_data = '0;
    foreach (sec_tab[i]) sec_tab[i] = '0;
    sec_count = '0;
    reloc_seq = '0;
    err_flag = 1'b0;
    img_present = 1'b0;
    img_size = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    noise = '{ROW_REQ, '{ACT_UNUSED, 1'b1, 1'b1, '1, '1, 1'b1, '1}, '0, 1'b0, '0};
    dir_rows.push_back(reloc_row(1'b0, 5'd0, 64'd0, 16'd0, 1'b1, 1'b0));
    dir_rows.push_back(reloc_row(1'b1, 5'd31, '1, 16'd1, 1'b1, 1'b0));
    dir_rows.push_back(final_row(1'b1));
    dir_rows.push_back(noise);
    dir_rows.push_back(final_row(1'b0));
    dir_rows.push_back(image_row(1'b1, 64'h100));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h0, 64'h80));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h40, 64'h80));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'hF0, 64'h20));
    dir_rows.push_back(load_row(1'b0, 1'b0, 64'h0, 64'h0));
    dir_rows.push_back(load_row(1'b1, 1'b1, 64'h0, '1));
    dir_rows.push_back(load_row(1'b1, 1'b0, '1, '1));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h10, 64'h0));
    dir_rows.push_back(reloc_row(1'b1, 5'd0, 64'h7F, 16'd0, 1'b0, 1'b0));
    dir_rows.push_back(reloc_row(1'b1, 5'd0, 64'h80, 16'd1, 1'b0, 1'b1));
    dir_rows.push_back(reloc_row(1'b1, 5'd3, 64'h0, 16'd2, 1'b1, 1'b0));
    dir_rows.push_back(reloc_row(1'b1, 5'd4, '1, 16'd3, 1'b0, 1'b0));
    dir_rows.push_back(reloc_row(1'b1, 5'd7, 64'h0, 16'd4, 1'b1, 1'b0));
    dir_rows.push_back(reloc_row(1'b1, 5'd6, 64'h0, 16'd5, 1'b0, 1'b1));
    dir_rows.push_back(validate_row());
    dir_rows.push_back(image_row(1'b0, '1));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h0, 64'h10));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h8, '1));
    dir_rows.push_back(validate_row());
    dir_rows.push_back(image_row(1'b1, 64'h0));
    dir_rows.push_back(load_row(1'b1, 1'b0, 64'h0, 64'h1));
    dir_rows.push_back(validate_row());

    foreach (dir_rows[k]) begin
      case (dir_rows[k].kind)
        ROW_CFG: set_image(dir_rows[k].img_p, dir_rows[k].img_s);
        ROW_CHK: send_request(dir_rows[k].req, 1'b1, dir_rows[k].want);
        default: send_request(dir_rows[k].req, 1'b0, '0);
      endcase
    end

    // Fill the table past capacity so that the last load is dropped.
    set_image(1'b1, '1);
    repeat (MAX_SECTIONS + 1) send_request(random_load(), 1'b0, '0);
    send_request(make_req(ACT_VALIDATE), 1'b0, '0);

    // Keep offering relocations while the receiver holds off so that the input stalls.
    repeat (3) send_request(random_load(), 1'b0, '0);
    hold_request = 1'b1;
    repeat (HOLD_ITEMS) send_request(random_reloc(), 1'b0, '0);
    send_request(make_req(ACT_VALIDATE), 1'b0, '0);

    random_items = 0;
    while (random_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) == 0) begin
        case ($urandom_range(0, 3))
          0: set_image(1'($urandom), 64'd0);
          1: set_image(1'($urandom), '1);
          2: set_image(1'b1, 64'($urandom_range('h100, 'h400)));
          default: set_image(1'($urandom), {$urandom, $urandom});
        endcase
      end
      r = $urandom_range(0, 19);
      n = (r < 16) ? $urandom_range(0, 6) : (r < 19) ? $urandom_range(7, 16) :
          $urandom_range(30, 34);
      for (int s = 0; s < n; s++) begin
        send_request(random_load(), 1'b0, '0);
        random_items++;
        if ($urandom_range(0, 3) == 0) begin
          send_request(random_reloc(), 1'b0, '0);
          random_items++;
        end
        if ($urandom_range(0, 19) == 0) send_request(make_req(ACT_UNUSED), 1'b0, '0);
      end
      repeat ($urandom_range(0, 3)) begin
        send_request(random_reloc(), 1'b0, '0);
        random_items++;
      end
      if ($urandom_range(0, 9) != 0) begin
        send_request(make_req(ACT_VALIDATE), 1'b0, '0);
        random_items++;
      end
    end
    send_request(make_req(ACT_VALIDATE), 1'b0, '0);

    drain();
    if (mismatches == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  int stall_tick = 0;
  logic [1:0] stall_mode = 2'd0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin : result_check
    report_t due;
    report_t got;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        got = '{out_report_kind, out_item_index, out_missing_entry, out_out_of_bounds,
                out_overlap_mask, out_reloc_out_of_range, out_format_error, out_last};
        if (reports_due.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected report: kind %0d index %0d", got.kind, got.index);
        end else begin
          due = reports_due.pop_front();
          if (got.kind !== due.kind || got.index !== due.index ||
              got.missing !== due.missing || got.oob !== due.oob ||
              got.mask !== due.mask || got.rr !== due.rr ||
              got.ferr !== due.ferr || got.last !== due.last) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"report mismatch: expected kind %0d index %0d missing %0b oob %0b ",
                        "mask %h range %0b ferr %0b last %0b, got kind %0d index %0d ",
                        "missing %0b oob %0b mask %h range %0b ferr %0b last %0b"},
                       due.kind, due.index, due.missing, due.oob, due.mask, due.rr,
                       due.ferr, due.last, got.kind, got.index, got.missing, got.oob,
                       got.mask, got.rr, got.ferr, got.last);
          end
        end
      end
      stall_tick <= stall_tick + 1;
      if (stall_tick % 64 == 0) stall_mode <= 2'($urandom_range(0, 3));
      if (hold_request && !hold_done) begin
        hold_done <= 1'b1;
        hold_left <= HOLD_CYCLES;
        out_stall <= 1'b1;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          2'd0: out_stall <= 1'b0;
          2'd1: out_stall <= ($urandom_range(0, 2) == 0);
          2'd2: out_stall <= stall_tick[0];
          default: out_stall <= (stall_tick % 8 < 3);
        endcase
      end
    end
  end

  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
        $display("tb NOT OK");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

endmodule
